// File: rtl/fdf_pkg.sv
package fdf_pkg;

  // Default configuration of the formatter.
  localparam int VALUE_WIDTH_DEF  = 32;
  localparam int MAX_DECIMALS_DEF = 10;

  // Width of the decimal-place field on the request.
  localparam int DP_W = 4;

  // ASCII codes emitted by the block.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // One formatting request.
  typedef struct packed {
    logic [31:0]     magnitude;
    logic [DP_W-1:0] decimal_places;
    logic            negative;
  } in_req_t;

  // One emitted character.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_res_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_SIGN,
    ST_INT,
    ST_POINT,
    ST_FRAC
  } state_t;

  // Source of the next output character.
  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_POINT,
    SEL_ZERO,
    SEL_DIGIT
  } char_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      convert;
    logic      scan;
    logic      pos_load_int;
    logic      pos_load_frac;
    logic      pos_dec;
    logic      emit;
    char_sel_t sel;
    logic      last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;
    logic neg;
    logic int_digits;
    logic has_frac;
    logic int_end;
    logic frac_end;
  } ctrl_sts_t;

endpackage

// File: rtl/fixed_point_decimal_formatter.sv
// Formats an unsigned magnitude with a decimal-place count and a sign flag as a run
// of ASCII characters, one per strobe on out_valid, with out_res.last marking the
// final one. A request is taken when start is high and busy is low. The receiver
// cannot stall: each character is on out_res for exactly one cycle and must be
// captured then. After acceptance, a request runs through shift-and-add-3 conversion
// (one input bit per cycle) and then the setup states ST_SCAN and ST_SIGN. ST_SIGN
// also emits the minus sign when there is one. The other characters then follow one
// per cycle. Busy stays high until the last character has been emitted, so a new
// request is not taken while one is in progress. The last character is on out_res in the
// first cycle with busy low, and the next request may be taken at the edge that
// ends that cycle.
module fixed_point_decimal_formatter
  import fdf_pkg::*;
#(
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF,
  parameter int MAX_DECIMALS = MAX_DECIMALS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencing of conversion and character emission.
  fdf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // BCD conversion, digit selection and output register.
  fdf_datapath #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .MAX_DECIMALS (MAX_DECIMALS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// File: rtl/fdf_datapath.sv
module fdf_datapath
  import fdf_pkg::*;
#(
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF,
  parameter int MAX_DECIMALS = MAX_DECIMALS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_req_t   in_req,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts,
  output logic      out_valid,
  output out_res_t  out_res
);

  // Decimal digits needed for a VALUE_WIDTH-bit value (log10(2) ~ 1233/4096).
  localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int SLOTS      = (NUM_DIGITS > MAX_DECIMALS) ? NUM_DIGITS : MAX_DECIMALS;
  localparam int POS_W      = $clog2(SLOTS + 1);
  localparam int CNT_W      = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int CLAMP_W    = (POS_W > DP_W) ? POS_W : DP_W;

  logic [VALUE_WIDTH-1:0]       bin_r;
  logic [NUM_DIGITS-1:0][3:0]   bcd_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [POS_W-1:0]             dec_r;
  logic                         neg_r;
  logic [POS_W-1:0]             n_r;
  logic [POS_W-1:0]             pos_r;
  logic                         out_valid_r;
  out_res_t                     out_res_r;

  logic [VALUE_WIDTH+31:0]      mag_ext;
  logic [CLAMP_W-1:0]           dp_ext;
  logic [POS_W-1:0]             dec_clamped;
  logic [NUM_DIGITS-1:0][3:0]   bcd_adj;
  logic [NUM_DIGITS-1:0][3:0]   bcd_shift;
  logic [POS_W-1:0]             n_calc;
  logic [3:0]                   digit;
  logic [7:0]                   char_nxt;

  // Fit the request magnitude to VALUE_WIDTH bits and clamp the decimal places.
  assign mag_ext     = {{VALUE_WIDTH{1'b0}}, in_req.magnitude};
  assign dp_ext      = CLAMP_W'(in_req.decimal_places);
  assign dec_clamped = (dp_ext > CLAMP_W'(MAX_DECIMALS)) ? POS_W'(MAX_DECIMALS)
                                                         : POS_W'(dp_ext);

  // One shift-and-add-3 step of the binary to BCD conversion.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
    bcd_shift[0] = {bcd_adj[0][2:0], bin_r[VALUE_WIDTH-1]};
    for (int i = 1; i < NUM_DIGITS; i++) begin
      bcd_shift[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
    end
  end

  // Count of significant digits: one above the highest nonzero digit.
  always_comb begin
    n_calc = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        n_calc = POS_W'(i + 1);
      end
    end
  end

  // Digit at the current position; positions beyond the converted digits read zero.
  always_comb begin
    digit = 4'd0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (pos_r == POS_W'(i)) begin
        digit = bcd_r[i];
      end
    end
  end

  // Character selection.
  always_comb begin
    case (cmd.sel)
      SEL_MINUS: char_nxt = CH_MINUS;
      SEL_POINT: char_nxt = CH_POINT;
      SEL_ZERO:  char_nxt = CH_ZERO;
      SEL_DIGIT: char_nxt = CH_ZERO + {4'd0, digit};
      default:   char_nxt = CH_ZERO;
    endcase
  end

  // Conversion and position registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r <= mag_ext[VALUE_WIDTH-1:0];
      bcd_r <= '0;
      cnt_r <= '0;
      dec_r <= dec_clamped;
      neg_r <= in_req.negative;
    end else if (cmd.convert) begin
      bin_r <= {bin_r[VALUE_WIDTH-2:0], 1'b0};
      bcd_r <= bcd_shift;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.scan) begin
      n_r <= n_calc;
    end
    if (cmd.pos_load_int) begin
      pos_r <= n_r - POS_W'(1);
    end else if (cmd.pos_load_frac) begin
      pos_r <= dec_r - POS_W'(1);
    end else if (cmd.pos_dec) begin
      pos_r <= pos_r - POS_W'(1);
    end
  end

  // Output register: one strobe per character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_res_r.character <= char_nxt;
      out_res_r.last      <= cmd.last;
    end
  end

  // Status to the controller.
  assign sts.conv_done  = (cnt_r == CNT_W'(VALUE_WIDTH - 1));
  assign sts.neg        = neg_r;
  assign sts.int_digits = (n_r > dec_r);
  assign sts.has_frac   = (dec_r != '0);
  assign sts.int_end    = (pos_r == dec_r);
  assign sts.frac_end   = (pos_r == '0);

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: rtl/fdf_ctrl.sv
module fdf_ctrl
  import fdf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ctrl_sts_t sts,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_ZERO;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd.convert = 1'b1;
        if (sts.conv_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = ST_SIGN;
      end
      ST_SIGN: begin
        cmd.pos_load_int = 1'b1;
        if (sts.neg) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_MINUS;
        end
        state_nxt = ST_INT;
      end
      ST_INT: begin
        cmd.emit = 1'b1;
        if (sts.int_digits) begin
          // Integer digits run from the top digit down to the decimal point.
          cmd.sel  = SEL_DIGIT;
          cmd.last = !sts.has_frac && sts.int_end;
          if (sts.int_end) begin
            state_nxt = sts.has_frac ? ST_POINT : ST_IDLE;
          end else begin
            cmd.pos_dec = 1'b1;
          end
        end else begin
          // No integer digits: a single zero is emitted, in front of the point if there is one.
          cmd.sel   = SEL_ZERO;
          cmd.last  = !sts.has_frac;
          state_nxt = sts.has_frac ? ST_POINT : ST_IDLE;
        end
      end
      ST_POINT: begin
        cmd.emit          = 1'b1;
        cmd.sel           = SEL_POINT;
        cmd.pos_load_frac = 1'b1;
        state_nxt         = ST_FRAC;
      end
      ST_FRAC: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_DIGIT;
        cmd.last = sts.frac_end;
        if (sts.frac_end) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.pos_dec = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
